// File: rtl/core/sse_pkg.sv
// ----------------------------------------------------------------------------
// sse_pkg
// Shared codes and types of the structure table string extractor.
// ----------------------------------------------------------------------------
package sse_pkg;

  localparam int unsigned PhaseW = 2;

  localparam logic [PhaseW-1:0] PH_TYPE      = 2'd0;
  localparam logic [PhaseW-1:0] PH_FORMATTED = 2'd1;
  localparam logic [PhaseW-1:0] PH_SKIP      = 2'd2;
  localparam logic [PhaseW-1:0] PH_EMIT      = 2'd3;

  localparam logic [1:0] KIND_CHAR     = 2'd0;
  localparam logic [1:0] KIND_DONE     = 2'd1;
  localparam logic [1:0] KIND_NOTFOUND = 2'd2;

  localparam logic [7:0] CFG_WANTED_TYPE     = 8'd0;
  localparam logic [7:0] CFG_STRING_OFFSET   = 8'd1;
  localparam logic [7:0] CFG_STRUCTURE_COUNT = 8'd2;
  localparam logic [7:0] CFG_TABLE_LENGTH    = 8'd3;

  localparam logic [15:0] POS_MAX      = 16'hFFFF;
  localparam logic [7:0]  MIN_FMT_LEN  = 8'd4;

  typedef struct packed {
    logic [7:0]  wanted_type;
    logic [7:0]  string_field_offset;
    logic [15:0] structure_count;
    logic [15:0] table_length;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] char_byte;
    logic [1:0] kind;
    logic       last;
  } result_t;

endpackage

// File: rtl/core/sse_walker.sv
// ----------------------------------------------------------------------------
// sse_walker
// Walks the structure table one byte per accepted item and produces at most
// one result for each byte.
// ----------------------------------------------------------------------------
module sse_walker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic [7:0]           table_byte,
  input  logic                 table_start,
  input  sse_pkg::cfg_t        cfg,
  output sse_pkg::result_t     res
);

  logic [sse_pkg::PhaseW-1:0] phase_r, phase_nxt, phase_c;
  logic [7:0]  byte_in_struct_r, byte_in_struct_nxt;
  logic [7:0]  fmt_len_r, fmt_len_nxt, fmt_len_c;
  logic [15:0] structs_left_r, structs_left_nxt, structs_c;
  logic [15:0] pos_r, pos_nxt, pos_c;
  logic        prev_zero_r, prev_zero_nxt;
  logic [7:0]  string_number_r, string_number_nxt, string_number_c;
  logic [7:0]  string_index_r, string_index_nxt;
  logic        matched_r, matched_nxt, matched_c;
  logic        finished_r, finished_nxt;
  logic        emit_end;

  always_comb begin
    phase_nxt          = phase_r;
    byte_in_struct_nxt = byte_in_struct_r;
    fmt_len_nxt        = fmt_len_r;
    structs_left_nxt   = structs_left_r;
    pos_nxt            = pos_r;
    prev_zero_nxt      = prev_zero_r;
    string_number_nxt  = string_number_r;
    string_index_nxt   = string_index_r;
    matched_nxt        = matched_r;
    finished_nxt       = finished_r;
    res                = '0;
    emit_end           = 1'b0;
    phase_c            = table_start ? sse_pkg::PH_TYPE : phase_r;
    pos_c              = table_start ? 16'd0 : pos_r;
    structs_c          = table_start ? cfg.structure_count : structs_left_r;
    fmt_len_c          = fmt_len_r;
    string_number_c    = string_number_r;
    matched_c          = matched_r;

    if (step && (table_start || !finished_r)) begin
      finished_nxt     = 1'b0;
      phase_nxt        = phase_c;
      structs_left_nxt = structs_c;
      pos_nxt          = (pos_c != sse_pkg::POS_MAX) ? pos_c + 16'd1 : pos_c;

      if (pos_c >= cfg.table_length) begin
        res.valid = 1'b1;
        res.kind  = (phase_c == sse_pkg::PH_EMIT) ? sse_pkg::KIND_DONE
                                                  : sse_pkg::KIND_NOTFOUND;
        emit_end  = 1'b1;
      end else begin
        case (phase_c)
          sse_pkg::PH_TYPE: begin
            if (structs_c == 16'd0) begin
              res.valid = 1'b1;
              res.kind  = sse_pkg::KIND_NOTFOUND;
              emit_end  = 1'b1;
            end else begin
              structs_left_nxt   = structs_c - 16'd1;
              matched_c          = (table_byte == cfg.wanted_type);
              matched_nxt        = matched_c;
              string_number_nxt  = (matched_c && cfg.string_field_offset == 8'd0)
                                   ? table_byte : 8'd0;
              byte_in_struct_nxt = 8'd1;
              phase_nxt          = sse_pkg::PH_FORMATTED;
            end
          end
          sse_pkg::PH_FORMATTED: begin
            if (byte_in_struct_r == 8'd1) begin
              fmt_len_c = (table_byte < sse_pkg::MIN_FMT_LEN) ? sse_pkg::MIN_FMT_LEN
                                                               : table_byte;
            end
            fmt_len_nxt = fmt_len_c;
            if (matched_r && byte_in_struct_r == cfg.string_field_offset) begin
              string_number_c = table_byte;
            end
            string_number_nxt = string_number_c;
            if ({1'b0, byte_in_struct_r} + 9'd1 >= {1'b0, fmt_len_c}) begin
              if (matched_r) begin
                if (string_number_c == 8'd0) begin
                  res.valid = 1'b1;
                  res.kind  = sse_pkg::KIND_DONE;
                  emit_end  = 1'b1;
                end else begin
                  phase_nxt        = sse_pkg::PH_EMIT;
                  string_index_nxt = 8'd1;
                  prev_zero_nxt    = 1'b1;
                end
              end else begin
                phase_nxt     = sse_pkg::PH_SKIP;
                prev_zero_nxt = 1'b0;
              end
            end else begin
              byte_in_struct_nxt = byte_in_struct_r + 8'd1;
            end
          end
          sse_pkg::PH_SKIP: begin
            if (table_byte == 8'd0 && prev_zero_r) begin
              phase_nxt = sse_pkg::PH_TYPE;
            end else begin
              prev_zero_nxt = (table_byte == 8'd0);
            end
          end
          default: begin
            if (table_byte != 8'd0) begin
              prev_zero_nxt = 1'b0;
              if (string_index_r == string_number_r) begin
                res.valid     = 1'b1;
                res.char_byte = table_byte;
                res.kind      = sse_pkg::KIND_CHAR;
              end
            end else if (prev_zero_r || string_index_r == string_number_r) begin
              res.valid = 1'b1;
              res.kind  = sse_pkg::KIND_DONE;
              emit_end  = 1'b1;
            end else begin
              string_index_nxt = string_index_r + 8'd1;
              prev_zero_nxt    = 1'b1;
            end
          end
        endcase
      end

      if (emit_end) begin
        res.last     = 1'b1;
        finished_nxt = 1'b1;
        phase_nxt    = sse_pkg::PH_TYPE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= sse_pkg::PH_TYPE;
      byte_in_struct_r <= 8'd0;
      fmt_len_r        <= 8'd0;
      structs_left_r   <= 16'd0;
      pos_r            <= 16'd0;
      prev_zero_r      <= 1'b0;
      string_number_r  <= 8'd0;
      string_index_r   <= 8'd0;
      matched_r        <= 1'b0;
      finished_r       <= 1'b1;
    end else begin
      phase_r          <= phase_nxt;
      byte_in_struct_r <= byte_in_struct_nxt;
      fmt_len_r        <= fmt_len_nxt;
      structs_left_r   <= structs_left_nxt;
      pos_r            <= pos_nxt;
      prev_zero_r      <= prev_zero_nxt;
      string_number_r  <= string_number_nxt;
      string_index_r   <= string_index_nxt;
      matched_r        <= matched_nxt;
      finished_r       <= finished_nxt;
    end
  end

endmodule

// File: rtl/core/smbios_struct_string_extractor.sv
// ----------------------------------------------------------------------------
// smbios_struct_string_extractor
// Finds the first structure of a configured type in a streamed table and
// returns the characters of one of its strings.
// ----------------------------------------------------------------------------
// The block takes one table byte per clock cycle while in_ready is high, and
// each byte gives at most one result through the output register. A byte is
// taken even while a result waits, as long as the output register is empty or
// is being emptied in the same cycle. A byte with in_table_start high restarts
// the walk and loads the structure count. Configuration is written through
// the cfg channel, which is always ready, and must only change while no
// table is being walked.
module smbios_struct_string_extractor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_table_byte,
  input  logic        in_table_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_char_byte,
  output logic [1:0]  out_kind,
  output logic        out_last
);

  sse_pkg::cfg_t    cfg_r;
  sse_pkg::result_t res;
  logic             step;
  logic             out_valid_r;
  logic [7:0]       out_char_byte_r;
  logic [1:0]       out_kind_r;
  logic             out_last_r;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign step      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wanted_type         <= 8'd1;
      cfg_r.string_field_offset <= 8'd7;
      cfg_r.structure_count     <= 16'd0;
      cfg_r.table_length        <= 16'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        sse_pkg::CFG_WANTED_TYPE:     cfg_r.wanted_type         <= cfg_data[7:0];
        sse_pkg::CFG_STRING_OFFSET:   cfg_r.string_field_offset <= cfg_data[7:0];
        sse_pkg::CFG_STRUCTURE_COUNT: cfg_r.structure_count     <= cfg_data;
        sse_pkg::CFG_TABLE_LENGTH:    cfg_r.table_length        <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  sse_walker u_walker (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .table_byte  (in_table_byte),
    .table_start (in_table_start),
    .cfg         (cfg_r),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_char_byte_r <= res.char_byte;
      out_kind_r      <= res.kind;
      out_last_r      <= res.last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_char_byte = out_char_byte_r;
  assign out_kind      = out_kind_r;
  assign out_last      = out_last_r;

endmodule

// File: tb/sse_checker.sv
// ----------------------------------------------------------------------------
// sse_checker
// Watches the channels of the structure table string extractor, predicts
// every result from the accepted table bytes and compares it with the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sse_checker
  import sse_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_table_byte,
  input  logic        in_table_start,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_char_byte,
  input  logic [1:0]  out_kind,
  input  logic        out_last,
  output int          fail_count,
  output int          pending,
  output logic        walk_idle
);

  logic [7:0]  cfg_type;
  logic [7:0]  cfg_offset;
  logic [15:0] cfg_count;
  logic [15:0] cfg_len;

  logic [PhaseW-1:0] phase;
  logic [7:0]  in_struct_idx;
  logic [7:0]  fmt_len;
  logic [15:0] structs_remaining;
  logic [15:0] pos_ctr;
  logic        prev_zero;
  logic [7:0]  sel_string;
  logic [7:0]  cur_string;
  logic        is_match;
  logic        walk_done;

  result_t results_due[$];
  result_t got;
  result_t want;

  initial begin
    fail_count = 0;
    pending = 0;
    walk_idle = 1'b1;
  end

  task automatic note_result(input logic [7:0] ch, input logic [1:0] kind);
    result_t r;
    r.valid = 1'b1;
    r.char_byte = ch;
    r.kind = kind;
    r.last = (kind != KIND_CHAR);
    results_due.push_back(r);
    if (kind != KIND_CHAR) begin
      walk_done = 1'b1;
      phase = PH_TYPE;
    end
  endtask

  task automatic walk_table_byte(input logic [7:0] b, input logic st);
    logic [15:0] pos;
    if (st) begin
      phase = PH_TYPE;
      pos_ctr = 16'd0;
      structs_remaining = cfg_count;
      walk_done = 1'b0;
    end else if (walk_done) begin
      return;
    end
    pos = pos_ctr;
    if (pos_ctr != POS_MAX) pos_ctr = pos_ctr + 16'd1;
    if (pos >= cfg_len) begin
      note_result(8'h00, (phase == PH_EMIT) ? KIND_DONE : KIND_NOTFOUND);
      return;
    end
    case (phase)
      PH_TYPE: begin
        if (structs_remaining == 16'd0) begin
          note_result(8'h00, KIND_NOTFOUND);
          return;
        end
        structs_remaining = structs_remaining - 16'd1;
        is_match = (b == cfg_type);
        sel_string = (is_match && cfg_offset == 8'd0) ? b : 8'h00;
        in_struct_idx = 8'd1;
        phase = PH_FORMATTED;
      end
      PH_FORMATTED: begin
        if (in_struct_idx == 8'd1) fmt_len = (b < MIN_FMT_LEN) ? MIN_FMT_LEN : b;
        if (is_match && in_struct_idx == cfg_offset) sel_string = b;
        if ({1'b0, in_struct_idx} + 9'd1 >= {1'b0, fmt_len}) begin
          if (is_match) begin
            if (sel_string == 8'h00) begin
              note_result(8'h00, KIND_DONE);
            end else begin
              phase = PH_EMIT;
              cur_string = 8'd1;
              prev_zero = 1'b1;
            end
          end else begin
            phase = PH_SKIP;
            prev_zero = 1'b0;
          end
        end else begin
          in_struct_idx = in_struct_idx + 8'd1;
        end
      end
      PH_SKIP: begin
        if (b == 8'h00 && prev_zero) phase = PH_TYPE;
        else prev_zero = (b == 8'h00);
      end
      default: begin
        if (b != 8'h00) begin
          prev_zero = 1'b0;
          if (cur_string == sel_string) note_result(b, KIND_CHAR);
        end else if (prev_zero || cur_string == sel_string) begin
          note_result(8'h00, KIND_DONE);
        end else begin
          cur_string = cur_string + 8'd1;
          prev_zero = 1'b1;
        end
      end
    endcase
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      cfg_type = 8'd1;
      cfg_offset = 8'd7;
      cfg_count = 16'd0;
      cfg_len = 16'd0;
      phase = PH_TYPE;
      in_struct_idx = 8'd0;
      fmt_len = 8'd0;
      structs_remaining = 16'd0;
      pos_ctr = 16'd0;
      prev_zero = 1'b0;
      sel_string = 8'd0;
      cur_string = 8'd0;
      is_match = 1'b0;
      walk_done = 1'b1;
      results_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_WANTED_TYPE:     cfg_type = cfg_data[7:0];
          CFG_STRING_OFFSET:   cfg_offset = cfg_data[7:0];
          CFG_STRUCTURE_COUNT: cfg_count = cfg_data;
          CFG_TABLE_LENGTH:    cfg_len = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          $display("%0t: result with none expected, got kind %0d char %h last %b",
                   $time, out_kind, out_char_byte, out_last);
          fail_count++;
        end else begin
          want = results_due.pop_front();
          got.valid = 1'b1;
          got.char_byte = out_char_byte;
          got.kind = out_kind;
          got.last = out_last;
          if (got.char_byte !== want.char_byte) begin
            $display("%0t: char_byte expected %h, got %h", $time, want.char_byte, got.char_byte);
            fail_count++;
          end
          if (got.kind !== want.kind) begin
            $display("%0t: kind expected %0d, got %0d", $time, want.kind, got.kind);
            fail_count++;
          end
          if (got.last !== want.last) begin
            $display("%0t: last expected %b, got %b", $time, want.last, got.last);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) walk_table_byte(in_table_byte, in_table_start);
    end
    pending = results_due.size();
    walk_idle = walk_done;
  end

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench top of the structure table string extractor: drives register
// writes and streams of well-formed, truncated and random tables under
// random stalls on both sides, and reports the verdict of the checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import sse_pkg::*;

  localparam int HoldAt   = 1500;
  localparam int HoldLen  = 400;
  localparam int CalmAt   = 400;
  localparam int CalmLen  = 900;
  localparam int ItemGoal = 1650;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = 8'h00;
  logic [15:0] cfg_data = 16'h0000;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_table_byte = 8'h00;
  logic        in_table_start = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_char_byte;
  logic [1:0]  out_kind;
  logic        out_last;

  int          fail_count;
  int          pending;
  logic        walk_idle;

  logic [7:0]  cur_type;
  logic [7:0]  cur_off;
  logic [7:0]  tbl_bytes[$];
  logic        tbl_starts[$];
  int          items_sent = 0;
  int          tbl_no = 0;
  int          rx_cycle = 0;
  bit          gaps_on = 1'b1;
  int          ph;
  int          n_tables;
  int          i;
  int          k;

  always #10 clk = ~clk;

  smbios_struct_string_extractor u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_table_byte  (in_table_byte),
    .in_table_start (in_table_start),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_char_byte  (out_char_byte),
    .out_kind       (out_kind),
    .out_last       (out_last)
  );

  sse_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_table_byte  (in_table_byte),
    .in_table_start (in_table_start),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_char_byte  (out_char_byte),
    .out_kind       (out_kind),
    .out_last       (out_last),
    .fail_count     (fail_count),
    .pending        (pending),
    .walk_idle      (walk_idle)
  );

  always @(posedge clk) begin
    if (!rst_n) begin
      rx_cycle <= 0;
      out_ready <= 1'b0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle >= HoldAt && rx_cycle < HoldAt + HoldLen) begin
        out_ready <= 1'b0;
      end else if (rx_cycle >= CalmAt && rx_cycle < CalmAt + CalmLen) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 22);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic st);
    if (gaps_on && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(99) < 90 ? $urandom_range(1, 3) : $urandom_range(4, 12))
        @(posedge clk);
    end
    items_sent++;
    in_valid <= 1'b1;
    in_table_byte <= b;
    in_table_start <= st;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic cfg_put(input logic [7:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic program_regs(input logic [7:0] t, input logic [7:0] o,
                              input logic [15:0] c, input logic [15:0] l);
    cur_type = t;
    cur_off = o;
    cfg_put(CFG_WANTED_TYPE, {8'($urandom), t});
    cfg_put(CFG_STRING_OFFSET, {8'($urandom), o});
    cfg_put(CFG_STRUCTURE_COUNT, c);
    cfg_put(CFG_TABLE_LENGTH, l);
    cfg_valid <= 1'b0;
  endtask

  // Runs the walk to its final result, then waits for the output to drain.
  task automatic settle_block();
    while (!walk_idle) send_byte(8'h00, 1'b0);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic push_byte(input logic [7:0] b, input logic st);
    tbl_bytes.push_back(b);
    tbl_starts.push_back(st);
  endtask

  task automatic build_table();
    int n_struct;
    int n_str;
    int slen;
    int flen;
    int eff;
    int s;
    int j;
    int c;
    logic [7:0] t;
    tbl_bytes.delete();
    tbl_starts.delete();
    if ($urandom_range(99) < 15) begin
      flen = $urandom_range(5, 40);
      for (j = 0; j < flen; j++) begin
        push_byte(($urandom_range(99) < 30) ? 8'h00 : 8'($urandom),
                  j != 0 && $urandom_range(99) < 5);
      end
    end else begin
      n_struct = $urandom_range(1, 6);
      for (s = 0; s < n_struct; s++) begin
        t = ($urandom_range(99) < 35) ? cur_type : 8'($urandom);
        n_str = $urandom_range(0, 4);
        if (cur_off >= 4 && cur_off <= 250 && $urandom_range(99) < 75) begin
          flen = cur_off + 1 + $urandom_range(0, 3);
        end else begin
          flen = $urandom_range(0, 12);
        end
        if (flen > 255) flen = 255;
        eff = (flen < 4) ? 4 : flen;
        push_byte(t, 1'b0);
        push_byte(8'(flen), 1'b0);
        for (j = 2; j < eff; j++) begin
          if (j == cur_off && $urandom_range(99) < 90) begin
            push_byte(8'($urandom_range(0, n_str + 1)), 1'b0);
          end else begin
            push_byte(8'($urandom), 1'b0);
          end
        end
        for (j = 0; j < n_str; j++) begin
          slen = ($urandom_range(99) < 10) ? 0 : $urandom_range(1, 5);
          for (c = 0; c < slen; c++) push_byte(8'($urandom_range(1, 255)), 1'b0);
          push_byte(8'h00, 1'b0);
        end
        if (n_str == 0) push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0);
      end
      if ($urandom_range(99) < 20) begin
        repeat ($urandom_range(1, tbl_bytes.size() - 1)) begin
          void'(tbl_bytes.pop_back());
          void'(tbl_starts.pop_back());
        end
      end
    end
    tbl_starts[0] = 1'b1;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: empty table length, so every start is not found.
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    settle_block();

    cfg_put(8'($urandom_range(4, 255)), 16'($urandom));
    program_regs(8'h01, 8'h04, 16'd2, 16'hFFFF);
    // Second string of a matching structure.
    tbl_bytes = '{8'h01, 8'h05, 8'hAA, 8'h55, 8'h02, 8'h41, 8'h00, 8'h42, 8'h43,
                  8'h00, 8'h00};
    for (k = 0; k < tbl_bytes.size(); k++) send_byte(tbl_bytes[k], k == 0);
    // Short length byte, then a match whose offset lies outside its area.
    tbl_bytes = '{8'h07, 8'h02, 8'h11, 8'h22, 8'h00, 8'h00, 8'h01, 8'h02, 8'h33,
                  8'h00};
    for (k = 0; k < tbl_bytes.size(); k++) send_byte(tbl_bytes[k], k == 0);

    ph = 0;
    while (items_sent < ItemGoal || ph < 6) begin
      settle_block();
      case (ph)
        0: program_regs(8'h00, 8'd0, 16'hFFFF, 16'd300);
        1: program_regs(8'hFF, 8'd1, 16'd3, 16'hFFFF);
        2: program_regs(8'($urandom), 8'd2, 16'd0, 16'hFFFF);
        3: program_regs(8'($urandom), 8'd3, 16'd10, 16'd0);
        4: program_regs(8'($urandom), 8'd255, 16'd8, 16'hFFFF);
        5: program_regs(8'($urandom_range(0, 3)), 8'd200, 16'd4, 16'hFFFF);
        default: begin
          program_regs(8'($urandom),
                       ($urandom_range(99) < 80) ? 8'($urandom_range(4, 12))
                                                 : 8'($urandom_range(4, 60)),
                       16'($urandom_range(1, 10)),
                       ($urandom_range(99) < 70) ? 16'hFFFF
                                                 : 16'($urandom_range(8, 150)));
        end
      endcase
      n_tables = $urandom_range(6, 12);
      for (i = 0; i < n_tables; i++) begin
        gaps_on = !(tbl_no >= 30 && tbl_no < 55);
        build_table();
        for (k = 0; k < tbl_bytes.size(); k++) send_byte(tbl_bytes[k], tbl_starts[k]);
        tbl_no++;
      end
      ph++;
    end

    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb: done, errors");
    $finish;
  end

endmodule

// File: files.f
rtl/core/sse_pkg.sv
rtl/core/sse_walker.sv
rtl/core/smbios_struct_string_extractor.sv
tb/sse_checker.sv
tb/tb.sv
